// ===== sv/zip_directory_entry_parser_core_assert.svh =====
// assertion helpers for the zip directory parser
`ifndef ZIP_DIRECTORY_ENTRY_PARSER_CORE_ASSERT_SVH
`define ZIP_DIRECTORY_ENTRY_PARSER_CORE_ASSERT_SVH

// same-cycle implication, checked while out of reset
`define ZDP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked while out of reset
`define ZDP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/zdp_pkg.sv =====
package zdp_pkg;

  localparam logic [31:0] SigLocal   = 32'h04034b50;
  localparam logic [31:0] SigCentral = 32'h02014b50;
  localparam logic [31:0] SigEnd     = 32'h06054b50;

  localparam int unsigned EndPosW = 5;
  localparam int unsigned RecPosW = 18;
  localparam int unsigned LocPosW = 5;

  localparam logic [EndPosW-1:0] EndLast      = EndPosW'(22 - 1);
  localparam logic [LocPosW-1:0] LocLast      = LocPosW'(30 - 1);
  localparam logic [RecPosW-1:0] CentralFixed = RecPosW'(46);
  localparam logic [RecPosW-1:0] CentralLast  = RecPosW'(46 - 1);
  localparam logic [32:0]        LocalSize    = 33'd30;

  // result slots behind the parser: two per request plus one waiting
  localparam int unsigned QueueDepth = 3;

  typedef enum logic [1:0] {
    CMD_END     = 2'd0,
    CMD_CENTRAL = 2'd1,
    CMD_LOCAL   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_DIR   = 2'd0,
    KIND_NAME  = 2'd1,
    KIND_ENTRY = 2'd2,
    KIND_DATA  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_END     = 3'd1,
    ST_BAD_CENTRAL = 3'd2,
    ST_BAD_LOCAL   = 3'd3,
    ST_COMPRESSED  = 3'd4,
    ST_NO_MORE     = 3'd5
  } status_e;

  typedef struct packed {
    kind_e       kind;
    status_e     status;
    logic [15:0] entry_count;
    logic [31:0] directory_size;
    logic [31:0] full_size;
    logic [15:0] method;
    logic [31:0] local_offset;
    logic [15:0] name_length;
    logic [7:0]  name_byte;
    logic [32:0] data_start;
    logic        is_last;
  } res_t;

  typedef struct packed {
    logic [1:0] num;
    res_t       first;
    res_t       second;
  } push_t;

endpackage

// ===== sv/zdp_if.sv =====
interface zdp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] data_byte;

  modport source (output valid, output command, output data_byte, input ready);
  modport sink (input valid, input command, input data_byte, output ready);
endinterface

interface zdp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [2:0]  status;
  logic [15:0] entry_count;
  logic [31:0] directory_size;
  logic [31:0] full_size;
  logic [15:0] method;
  logic [31:0] local_offset;
  logic [15:0] name_length;
  logic [7:0]  name_byte;
  logic [32:0] data_start;
  logic        is_last;

  modport source (
    output valid, output result_kind, output status, output entry_count,
    output directory_size, output full_size, output method,
    output local_offset, output name_length, output name_byte,
    output data_start, output is_last, input ready
  );
  modport sink (
    input valid, input result_kind, input status, input entry_count,
    input directory_size, input full_size, input method,
    input local_offset, input name_length, input name_byte,
    input data_start, input is_last, output ready
  );
endinterface

// ===== sv/zip_directory_entry_parser_core.sv =====
// channel  dir  handshake        payload
// in_i     in   valid / ready    command, data_byte
// out_o    out  valid / ready    result_kind .. is_last (up to two results per request)
//
// one archive byte per cycle while ready: parse and field capture finish at accept edge
// a request yields zero, one or two results; they queue in a three-slot result buffer
// input ready while at most one result waits, so a stalled output still takes a byte
// a filename byte that also ends its record pushes two results: name, then entry info
// async active-low reset clears all counters, parser fields, error hold; no clearing pass
module zip_directory_entry_parser_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  zdp_in_if.sink    in_i,
  zdp_out_if.source out_o
);

  zdp_pkg::push_t push;
  logic           room;
  logic           accept;

  assign in_i.ready = room;
  assign accept     = in_i.valid && room;

  zdp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .command_i   (in_i.command),
    .data_byte_i (in_i.data_byte),
    .push_o      (push)
  );

  zdp_res_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .out_o  (out_o)
  );

endmodule

// ===== sv/zdp_parser.sv =====
module zdp_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [1:0]       command_i,
  input  logic [7:0]       data_byte_i,
  output zdp_pkg::push_t   push_o
);

  logic [zdp_pkg::EndPosW-1:0] end_pos_q, end_pos_d;
  logic [zdp_pkg::RecPosW-1:0] rec_pos_q, rec_pos_d;
  logic [zdp_pkg::LocPosW-1:0] loc_pos_q, loc_pos_d;
  logic [31:0] sig_q, sig_d;
  logic [15:0] total_q, total_d;
  logic [31:0] dir_q, dir_d;
  logic [15:0] seen_q, seen_d;
  logic [15:0] meth_q, meth_d;
  logic [31:0] size_q, size_d;
  logic [15:0] nlen_q, nlen_d;
  logic [15:0] xlen_q, xlen_d;
  logic [15:0] clen_q, clen_d;
  logic [31:0] off_q, off_d;
  logic [15:0] lnlen_q, lnlen_d;
  logic [15:0] lxlen_q, lxlen_d;
  logic        err_q, err_d;

  logic [31:0]                 sig_shift;
  logic [zdp_pkg::RecPosW-1:0] name_end;
  logic [zdp_pkg::RecPosW-1:0] rec_end;
  logic                        name_hit;
  logic                        last_hit;
  zdp_pkg::res_t               res0, res1;
  logic [1:0]                  num;

  assign sig_shift = {data_byte_i, sig_q[31:8]};
  assign name_end  = zdp_pkg::CentralFixed + zdp_pkg::RecPosW'(nlen_q);
  assign rec_end   = zdp_pkg::CentralLast + zdp_pkg::RecPosW'(nlen_q)
                   + zdp_pkg::RecPosW'(xlen_q) + zdp_pkg::RecPosW'(clen_q);
  assign name_hit  = (rec_pos_q >= zdp_pkg::CentralFixed) && (rec_pos_q < name_end);
  assign last_hit  = (rec_pos_q >= zdp_pkg::CentralLast) && (rec_pos_q == rec_end);

  always_comb begin
    end_pos_d = end_pos_q;
    rec_pos_d = rec_pos_q;
    loc_pos_d = loc_pos_q;
    sig_d     = sig_q;
    total_d   = total_q;
    dir_d     = dir_q;
    seen_d    = seen_q;
    meth_d    = meth_q;
    size_d    = size_q;
    nlen_d    = nlen_q;
    xlen_d    = xlen_q;
    clen_d    = clen_q;
    off_d     = off_q;
    lnlen_d   = lnlen_q;
    lxlen_d   = lxlen_q;
    err_d     = err_q;
    res0      = '0;
    res1      = '0;
    num       = 2'd0;

    if (accept_i) begin
      case (command_i)
        zdp_pkg::CMD_END: begin
          // first byte of an end record restarts the whole parse
          if (end_pos_q == '0) begin
            err_d     = 1'b0;
            rec_pos_d = '0;
            loc_pos_d = '0;
            seen_d    = '0;
          end
          if (end_pos_q < 5'd4) sig_d = sig_shift;
          if (end_pos_q == 5'd3 && sig_shift != zdp_pkg::SigEnd) begin
            res0.kind   = zdp_pkg::KIND_DIR;
            res0.status = zdp_pkg::ST_BAD_END;
            num         = 2'd1;
            err_d       = 1'b1;
            end_pos_d   = '0;
          end else begin
            if (end_pos_q == 5'd10) total_d[7:0]  = data_byte_i;
            if (end_pos_q == 5'd11) total_d[15:8] = data_byte_i;
            if (end_pos_q == 5'd12) dir_d[7:0]    = data_byte_i;
            if (end_pos_q == 5'd13) dir_d[15:8]   = data_byte_i;
            if (end_pos_q == 5'd14) dir_d[23:16]  = data_byte_i;
            if (end_pos_q == 5'd15) dir_d[31:24]  = data_byte_i;
            if (end_pos_q == zdp_pkg::EndLast) begin
              res0.kind           = zdp_pkg::KIND_DIR;
              res0.status         = zdp_pkg::ST_OK;
              res0.entry_count    = total_d;
              res0.directory_size = dir_d;
              num                 = 2'd1;
              end_pos_d           = '0;
            end else begin
              end_pos_d = end_pos_q + 5'd1;
            end
          end
        end

        zdp_pkg::CMD_CENTRAL: begin
          if (!err_q) begin
            if (rec_pos_q == '0 && seen_q == total_q) begin
              res0.kind   = zdp_pkg::KIND_ENTRY;
              res0.status = zdp_pkg::ST_NO_MORE;
              num         = 2'd1;
            end else begin
              if (rec_pos_q == '0) seen_d = seen_q + 16'd1;
              if (rec_pos_q < 18'd4) sig_d = sig_shift;
              if (rec_pos_q == 18'd3 && sig_shift != zdp_pkg::SigCentral) begin
                res0.kind   = zdp_pkg::KIND_ENTRY;
                res0.status = zdp_pkg::ST_BAD_CENTRAL;
                num         = 2'd1;
                err_d       = 1'b1;
                rec_pos_d   = '0;
              end else begin
                if (rec_pos_q == 18'd10) meth_d[7:0]   = data_byte_i;
                if (rec_pos_q == 18'd11) meth_d[15:8]  = data_byte_i;
                if (rec_pos_q == 18'd24) size_d[7:0]   = data_byte_i;
                if (rec_pos_q == 18'd25) size_d[15:8]  = data_byte_i;
                if (rec_pos_q == 18'd26) size_d[23:16] = data_byte_i;
                if (rec_pos_q == 18'd27) size_d[31:24] = data_byte_i;
                if (rec_pos_q == 18'd28) nlen_d[7:0]   = data_byte_i;
                if (rec_pos_q == 18'd29) nlen_d[15:8]  = data_byte_i;
                if (rec_pos_q == 18'd30) xlen_d[7:0]   = data_byte_i;
                if (rec_pos_q == 18'd31) xlen_d[15:8]  = data_byte_i;
                if (rec_pos_q == 18'd32) clen_d[7:0]   = data_byte_i;
                if (rec_pos_q == 18'd33) clen_d[15:8]  = data_byte_i;
                if (rec_pos_q == 18'd42) off_d[7:0]    = data_byte_i;
                if (rec_pos_q == 18'd43) off_d[15:8]   = data_byte_i;
                if (rec_pos_q == 18'd44) off_d[23:16]  = data_byte_i;
                if (rec_pos_q == 18'd45) off_d[31:24]  = data_byte_i;
                if (name_hit) begin
                  res0.kind      = zdp_pkg::KIND_NAME;
                  res0.status    = zdp_pkg::ST_OK;
                  res0.name_byte = data_byte_i;
                  num            = 2'd1;
                end
                if (last_hit) begin
                  // entry info follows the filename byte when both land here
                  if (name_hit) begin
                    res1.kind         = zdp_pkg::KIND_ENTRY;
                    res1.status       = zdp_pkg::ST_OK;
                    res1.full_size    = size_d;
                    res1.method       = meth_d;
                    res1.local_offset = off_d;
                    res1.name_length  = nlen_d;
                    num               = 2'd2;
                  end else begin
                    res0.kind         = zdp_pkg::KIND_ENTRY;
                    res0.status       = zdp_pkg::ST_OK;
                    res0.full_size    = size_d;
                    res0.method       = meth_d;
                    res0.local_offset = off_d;
                    res0.name_length  = nlen_d;
                    num               = 2'd1;
                  end
                  rec_pos_d = '0;
                end else begin
                  rec_pos_d = rec_pos_q + 18'd1;
                end
              end
            end
          end
        end

        zdp_pkg::CMD_LOCAL: begin
          if (!err_q) begin
            if (loc_pos_q < 5'd4) sig_d = sig_shift;
            if (loc_pos_q == 5'd3 && sig_shift != zdp_pkg::SigLocal) begin
              res0.kind   = zdp_pkg::KIND_DATA;
              res0.status = zdp_pkg::ST_BAD_LOCAL;
              num         = 2'd1;
              err_d       = 1'b1;
              loc_pos_d   = '0;
            end else begin
              if (loc_pos_q == 5'd26) lnlen_d[7:0]  = data_byte_i;
              if (loc_pos_q == 5'd27) lnlen_d[15:8] = data_byte_i;
              if (loc_pos_q == 5'd28) lxlen_d[7:0]  = data_byte_i;
              if (loc_pos_q == 5'd29) lxlen_d[15:8] = data_byte_i;
              if (loc_pos_q >= zdp_pkg::LocLast) begin
                res0.kind       = zdp_pkg::KIND_DATA;
                res0.status     = (meth_q != '0) ? zdp_pkg::ST_COMPRESSED : zdp_pkg::ST_OK;
                res0.method     = meth_q;
                res0.data_start = {1'b0, off_q} + zdp_pkg::LocalSize
                                + {17'd0, lnlen_d} + {17'd0, lxlen_d};
                num             = 2'd1;
                if (meth_q != '0) err_d = 1'b1;
                loc_pos_d = '0;
              end else begin
                loc_pos_d = loc_pos_q + 5'd1;
              end
            end
          end
        end

        default: begin
        end
      endcase
    end

    if (num == 2'd1) res0.is_last = 1'b1;
    if (num == 2'd2) res1.is_last = 1'b1;
  end

  assign push_o.num    = num;
  assign push_o.first  = res0;
  assign push_o.second = res1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_pos_q <= '0;
      rec_pos_q <= '0;
      loc_pos_q <= '0;
      sig_q     <= '0;
      total_q   <= '0;
      dir_q     <= '0;
      seen_q    <= '0;
      meth_q    <= '0;
      size_q    <= '0;
      nlen_q    <= '0;
      xlen_q    <= '0;
      clen_q    <= '0;
      off_q     <= '0;
      lnlen_q   <= '0;
      lxlen_q   <= '0;
      err_q     <= 1'b0;
    end else begin
      end_pos_q <= end_pos_d;
      rec_pos_q <= rec_pos_d;
      loc_pos_q <= loc_pos_d;
      sig_q     <= sig_d;
      total_q   <= total_d;
      dir_q     <= dir_d;
      seen_q    <= seen_d;
      meth_q    <= meth_d;
      size_q    <= size_d;
      nlen_q    <= nlen_d;
      xlen_q    <= xlen_d;
      clen_q    <= clen_d;
      off_q     <= off_d;
      lnlen_q   <= lnlen_d;
      lxlen_q   <= lxlen_d;
      err_q     <= err_d;
    end
  end

endmodule

// ===== sv/zdp_res_queue.sv =====
module zdp_res_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  zdp_pkg::push_t push_i,
  output logic           room_o,
  zdp_out_if.source      out_o
);

  localparam int unsigned Depth = zdp_pkg::QueueDepth;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  zdp_pkg::res_t   slot_q [Depth];
  zdp_pkg::res_t   slot_d [Depth];
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] cnt_ap;
  logic            pop;

  assign pop    = (cnt_q != '0) && out_o.ready;
  assign cnt_ap = cnt_q - CntW'(pop);
  // room for a full two-result request, independent of the output side
  assign room_o = (cnt_q <= CntW'(Depth - 2));

  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      if (pop && i < Depth - 1) slot_d[i] = slot_q[i + 1];
      else                      slot_d[i] = slot_q[i];
      if (push_i.num != 2'd0 && cnt_ap == CntW'(i)) slot_d[i] = push_i.first;
      if (push_i.num == 2'd2 && cnt_ap + CntW'(1) == CntW'(i)) slot_d[i] = push_i.second;
    end
    cnt_d = cnt_ap + CntW'(push_i.num);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Depth; i++) begin
      slot_q[i] <= slot_d[i];
    end
  end

  assign out_o.valid          = (cnt_q != '0);
  assign out_o.result_kind    = slot_q[0].kind;
  assign out_o.status         = slot_q[0].status;
  assign out_o.entry_count    = slot_q[0].entry_count;
  assign out_o.directory_size = slot_q[0].directory_size;
  assign out_o.full_size      = slot_q[0].full_size;
  assign out_o.method         = slot_q[0].method;
  assign out_o.local_offset   = slot_q[0].local_offset;
  assign out_o.name_length    = slot_q[0].name_length;
  assign out_o.name_byte      = slot_q[0].name_byte;
  assign out_o.data_start     = slot_q[0].data_start;
  assign out_o.is_last        = slot_q[0].is_last;

endmodule

// ===== sv/zdp_checker.sv =====
`include "zip_directory_entry_parser_core_assert.svh"

module zdp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  out_kind_i,
  input logic [2:0]  out_status_i,
  input logic [15:0] out_count_i,
  input logic [7:0]  out_name_byte_i,
  input logic [32:0] out_data_start_i,
  input logic        out_last_i
);

  `ZDP_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_kind_i) && $stable(out_name_byte_i) && $stable(out_data_start_i), "result changed while stalled")
  `ZDP_ASSERT_NOW(a_name_clean, out_valid_i && out_kind_i == zdp_pkg::KIND_NAME, out_status_i == zdp_pkg::ST_OK && out_count_i == '0 && out_data_start_i == '0, "filename result carries stray fields")
  `ZDP_ASSERT_NEXT(a_pair_order, out_valid_i && out_ready_i && !out_last_i, out_valid_i && out_kind_i == zdp_pkg::KIND_ENTRY && out_last_i, "filename byte not followed by entry info")
  `ZDP_ASSERT_NOW(a_ready_empty, !out_valid_i, in_ready_i, "input stalled with no result waiting")

endmodule

bind zip_directory_entry_parser_core zdp_checker u_zdp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_kind_i       (out_o.result_kind),
  .out_status_i     (out_o.status),
  .out_count_i      (out_o.entry_count),
  .out_name_byte_i  (out_o.name_byte),
  .out_data_start_i (out_o.data_start),
  .out_last_i       (out_o.is_last)
);
